### rtl/core/ifhr_pkg.sv
// Shared constants, status codes and control types of the fragment reassembly block.
package ifhr_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int MAX_HOLES_DEF = 8;

  localparam logic [15:0] MAX_BYTES_RST = 16'd1000;
  localparam int          HOLES_SAT     = 15;

  localparam logic [1:0] ST_PLACED  = 2'd0;
  localparam logic [1:0] ST_NO_HOLE = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  typedef struct packed {
    logic accept;
    logic cfg_wr;
    logic init_rst;
    logic init_wr;
    logic scan_clr;
    logic scan_step;
    logic commit;
  } ifhr_cmd_t;

  typedef struct packed {
    logic init_last;
    logic scan_last;
    logic out_free;
  } ifhr_sts_t;

endpackage

### rtl/core/ifhr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ifhr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### rtl/core/ifhr_ctrl.sv
// Controller state machine: table initialization sweep, fragment read, hole scan and writeback.
module ifhr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  ifhr_pkg::ifhr_sts_t sts,
  output ifhr_pkg::ifhr_cmd_t cmd
);
  import ifhr_pkg::*;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign cfg_ready = (state_r == S_IDLE) || (state_r == S_INIT);
  assign in_stall  = (state_r != S_IDLE) || cfg_valid;

  always_comb begin
    cmd           = '0;
    cmd.accept    = (state_r == S_IDLE) && in_valid && !cfg_valid;
    cmd.cfg_wr    = cfg_valid && cfg_ready;
    cmd.init_rst  = cfg_valid && cfg_ready;
    cmd.init_wr   = (state_r == S_INIT);
    cmd.scan_clr  = (state_r == S_READ);
    cmd.scan_step = (state_r == S_SCAN);
    cmd.commit    = (state_r == S_DONE) && sts.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        if (sts.init_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && !cfg_valid) state_nxt = S_READ;
      end
      S_READ: state_nxt = S_SCAN;
      S_SCAN: begin
        if (sts.scan_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
    if (cfg_valid && cfg_ready) state_nxt = S_INIT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/ifhr_dp.sv
// Datapath: per-slot hole table memory, fragment registers, hole scan, update and result register.
module ifhr_dp #(
  parameter int NUM_SLOTS = ifhr_pkg::NUM_SLOTS_DEF,
  parameter int MAX_HOLES = ifhr_pkg::MAX_HOLES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ifhr_pkg::ifhr_cmd_t cmd,
  output ifhr_pkg::ifhr_sts_t sts,
  input  logic [15:0]         cfg_max_datagram_bytes,
  input  logic [3:0]          in_datagram_slot,
  input  logic [12:0]         in_offset_units,
  input  logic [15:0]         in_fragment_length,
  input  logic                in_more_fragments,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [3:0]          out_holes_left,
  output logic                out_complete,
  output logic [15:0]         out_total_bytes
);
  import ifhr_pkg::*;

  localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int HIDX_W  = $clog2(MAX_HOLES);
  localparam int CNT_W   = $clog2(MAX_HOLES + 1);
  localparam int LEN_LSB = 1;
  localparam int VAL_LSB = 17;
  localparam int END_LSB = VAL_LSB + MAX_HOLES;
  localparam int STA_LSB = END_LSB + 16 * MAX_HOLES;
  localparam int ROW_W   = STA_LSB + 16 * MAX_HOLES;

  logic [15:0]       max_r;
  logic [SLOT_W-1:0] init_idx_r;
  logic [3:0]        slot_r;
  logic              slot_bad_r;
  logic              range_bad_r;
  logic              more_r;
  logic [15:0]       first_r;
  logic [15:0]       last_r;
  logic [16:0]       end_r;

  logic [HIDX_W-1:0] scan_idx_r;
  logic              hit_found_r, tail_found_r, free_found_r;
  logic [HIDX_W-1:0] hit_idx_r, tail_idx_r, free_idx_r;
  logic [15:0]       hit_s_r, hit_e_r, tail_s_r, tail_e_r;
  logic [CNT_W-1:0]  cnt_r;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [3:0]        out_holes_r;
  logic              out_complete_r;
  logic [15:0]       out_total_r;

  logic [ROW_W-1:0]  rd_row, wr_row, upd_row, init_row;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;

  logic [15:0]          start_a [MAX_HOLES];
  logic [15:0]          end_a   [MAX_HOLES];
  logic [MAX_HOLES-1:0] valid_v;
  logic                 known_c;
  logic [15:0]          len_c;

  logic [15:0]          start_n [MAX_HOLES];
  logic [15:0]          end_n   [MAX_HOLES];
  logic [MAX_HOLES-1:0] valid_n;
  logic                 known_n;
  logic [15:0]          len_n;
  logic [1:0]           status_c;
  logic                 do_wr, dec, inc;
  logic [CNT_W-1:0]     cnt_new;
  logic [3:0]           holes_c;

  logic [15:0] first_w;
  logic [16:0] end_w;
  logic [15:0] sel_s, sel_e;
  logic        sel_v;

  ifhr_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NUM_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wr_row),
    .raddr(ram_raddr),
    .rdata(rd_row)
  );

  assign ram_raddr = SLOT_W'(slot_r);
  assign ram_waddr = cmd.init_wr ? init_idx_r : SLOT_W'(slot_r);
  assign ram_we    = cmd.init_wr || (cmd.commit && do_wr);
  assign wr_row    = cmd.init_wr ? init_row : upd_row;

  assign first_w = {in_offset_units, 3'b000};
  assign end_w   = {1'b0, first_w} + {1'b0, in_fragment_length};

  // Unpack the slot row into per-hole fields.
  always_comb begin
    known_c = rd_row[0];
    len_c   = rd_row[LEN_LSB +: 16];
    valid_v = rd_row[VAL_LSB +: MAX_HOLES];
    for (int i = 0; i < MAX_HOLES; i++) begin
      start_a[i] = rd_row[STA_LSB + 16 * i +: 16];
      end_a[i]   = rd_row[END_LSB + 16 * i +: 16];
    end
  end

  assign sel_s = start_a[scan_idx_r];
  assign sel_e = end_a[scan_idx_r];
  assign sel_v = valid_v[scan_idx_r];

  // A fresh slot holds one hole covering the configured length, or no hole when that length is zero.
  always_comb begin
    init_row                   = '0;
    init_row[VAL_LSB]          = (max_r != 16'd0);
    init_row[END_LSB +: 16]    = max_r - 16'd1;
  end

  always_comb begin
    for (int i = 0; i < MAX_HOLES; i++) begin
      start_n[i] = start_a[i];
      end_n[i]   = end_a[i];
    end
    valid_n  = valid_v;
    known_n  = known_c;
    len_n    = len_c;
    status_c = ST_PLACED;
    do_wr    = 1'b0;
    dec      = 1'b0;
    inc      = 1'b0;
    if (slot_bad_r || range_bad_r) begin
      status_c = ST_INVALID;
    end else if (more_r || known_c) begin
      if (!more_r && (end_r != {1'b0, len_c})) begin
        status_c = ST_INVALID;
      end else if (!hit_found_r) begin
        status_c = ST_NO_HOLE;
      end else if ((first_r == hit_s_r) && (last_r == hit_e_r)) begin
        valid_n[hit_idx_r] = 1'b0;
        dec                = 1'b1;
        do_wr              = 1'b1;
      end else if (first_r == hit_s_r) begin
        start_n[hit_idx_r] = last_r + 16'd1;
        do_wr              = 1'b1;
      end else if (last_r == hit_e_r) begin
        end_n[hit_idx_r] = first_r - 16'd1;
        do_wr            = 1'b1;
      end else if (!free_found_r) begin
        status_c = ST_FULL;
      end else begin
        valid_n[free_idx_r] = 1'b1;
        start_n[free_idx_r] = last_r + 16'd1;
        end_n[free_idx_r]   = hit_e_r;
        end_n[hit_idx_r]    = first_r - 16'd1;
        inc                 = 1'b1;
        do_wr               = 1'b1;
      end
    end else begin
      // The last fragment sets the length to its own end and trims the tail hole to end before it, or drops it.
      if (!tail_found_r || (first_r < tail_s_r) || (last_r > tail_e_r)) begin
        status_c = ST_NO_HOLE;
      end else begin
        known_n = 1'b1;
        len_n   = end_r[15:0];
        do_wr   = 1'b1;
        if (first_r == tail_s_r) begin
          valid_n[tail_idx_r] = 1'b0;
          dec                 = 1'b1;
        end else begin
          end_n[tail_idx_r] = first_r - 16'd1;
        end
      end
    end
  end

  always_comb begin
    upd_row                    = '0;
    upd_row[0]                 = known_n;
    upd_row[LEN_LSB +: 16]     = len_n;
    upd_row[VAL_LSB +: MAX_HOLES] = valid_n;
    for (int i = 0; i < MAX_HOLES; i++) begin
      upd_row[STA_LSB + 16 * i +: 16] = start_n[i];
      upd_row[END_LSB + 16 * i +: 16] = end_n[i];
    end
  end

  assign cnt_new = cnt_r - CNT_W'(dec) + CNT_W'(inc);
  assign holes_c = (32'(cnt_new) > HOLES_SAT) ? 4'(HOLES_SAT) : 4'(cnt_new);

  assign sts.init_last = (init_idx_r == SLOT_W'(NUM_SLOTS - 1));
  assign sts.scan_last = (scan_idx_r == HIDX_W'(MAX_HOLES - 1));
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r      <= MAX_BYTES_RST;
      init_idx_r <= '0;
    end else begin
      if (cmd.cfg_wr) max_r <= cfg_max_datagram_bytes;
      if (cmd.init_rst) begin
        init_idx_r <= '0;
      end else if (cmd.init_wr) begin
        init_idx_r <= sts.init_last ? '0 : init_idx_r + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      slot_r      <= in_datagram_slot;
      slot_bad_r  <= (32'(in_datagram_slot) >= NUM_SLOTS);
      range_bad_r <= (in_fragment_length == 16'd0) || (end_w > 17'h10000);
      more_r      <= in_more_fragments;
      first_r     <= first_w;
      last_r      <= 16'(end_w - 17'd1);
      end_r       <= end_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r   <= '0;
      hit_found_r  <= 1'b0;
      tail_found_r <= 1'b0;
      free_found_r <= 1'b0;
      cnt_r        <= '0;
    end else if (cmd.scan_clr) begin
      scan_idx_r   <= '0;
      hit_found_r  <= 1'b0;
      tail_found_r <= 1'b0;
      free_found_r <= 1'b0;
      cnt_r        <= '0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + HIDX_W'(1);
      if (sel_v) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (!hit_found_r && (first_r >= sel_s) && (last_r <= sel_e)) begin
          hit_found_r <= 1'b1;
          hit_idx_r   <= scan_idx_r;
          hit_s_r     <= sel_s;
          hit_e_r     <= sel_e;
        end
        if (!tail_found_r || (sel_e > tail_e_r)) begin
          tail_found_r <= 1'b1;
          tail_idx_r   <= scan_idx_r;
          tail_s_r     <= sel_s;
          tail_e_r     <= sel_e;
        end
      end else if (!free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= scan_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= status_c;
      if (slot_bad_r) begin
        out_holes_r    <= 4'd0;
        out_complete_r <= 1'b0;
        out_total_r    <= 16'd0;
      end else begin
        out_holes_r    <= holes_c;
        out_complete_r <= (cnt_new == '0) && known_n;
        out_total_r    <= known_n ? len_n : 16'd0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_holes_left  = out_holes_r;
  assign out_complete    = out_complete_r;
  assign out_total_bytes = out_total_r;

endmodule

### rtl/core/ip_fragment_hole_reassembly.sv
// Top level of the hole-descriptor IP fragment reassembly block.
//
//   Channel | Ports                                   | Transfer when
//   --------+-----------------------------------------+-------------------------
//   in      | in_valid, in_stall, in_* fields         | in_valid && !in_stall
//   out     | out_valid, out_stall, out_* fields      | out_valid && !out_stall
//   cfg     | cfg_valid, cfg_ready, cfg_max_datagram_bytes | cfg_valid && cfg_ready
//
// A fragment passes through the transfer, a slot row read, a scan of each hole entry in turn
// through the shared compare unit, and a writeback.
// After reset and after every configuration write, an initialization sweep writes one
// slot row per cycle until all NUM_SLOTS rows are written, with in_stall held high.
// The result sits in an output register; writeback of the next fragment waits while it is stalled.
// cfg_ready is high only between fragments and during the sweep; an offered write holds in_stall.
module ip_fragment_hole_reassembly #(
  parameter int NUM_SLOTS = ifhr_pkg::NUM_SLOTS_DEF,
  parameter int MAX_HOLES = ifhr_pkg::MAX_HOLES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_datagram_slot,
  input  logic [12:0] in_offset_units,
  input  logic [15:0] in_fragment_length,
  input  logic        in_more_fragments,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [3:0]  out_holes_left,
  output logic        out_complete,
  output logic [15:0] out_total_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_max_datagram_bytes
);
  import ifhr_pkg::*;

  ifhr_cmd_t cmd;
  ifhr_sts_t sts;

  ifhr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ifhr_dp #(
    .NUM_SLOTS(NUM_SLOTS),
    .MAX_HOLES(MAX_HOLES)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_max_datagram_bytes(cfg_max_datagram_bytes),
    .in_datagram_slot      (in_datagram_slot),
    .in_offset_units       (in_offset_units),
    .in_fragment_length    (in_fragment_length),
    .in_more_fragments     (in_more_fragments),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_holes_left        (out_holes_left),
    .out_complete          (out_complete),
    .out_total_bytes       (out_total_bytes)
  );

endmodule
